// ===== hw/rtl/lcdnw_pkg.sv =====
package lcdnw_pkg;

   // Field widths fixed by the LCD bus and the register map
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned NIBBLE_W = 4;
   localparam int unsigned TICKS_W  = 16;
   localparam int unsigned COLUMN_W = 6;
   localparam int unsigned STEP_W   = 4;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // Register reset values
   localparam logic [TICKS_W-1:0]  WAIT_TICKS_RST   = 16'd50;
   localparam logic [TICKS_W-1:0]  SETTLE_TICKS_RST = 16'd20;
   localparam logic [COLUMN_W-1:0] LINE_LENGTH_RST  = 6'd16;
   localparam logic [BYTE_W-1:0]   WRAP_COMMAND_RST = 8'hC0;

   localparam logic [COLUMN_W-1:0] COLUMN_MAX = '1;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_TICKS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_LENGTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_COMMAND = 2'd3;

   // Operation codes on the request channel
   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_DATA    = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [BYTE_W-1:0] byte_value;
      logic              first_of_string;
   } req_type;

   typedef struct packed {
      logic                select_level;
      logic                enable_level;
      logic [NIBBLE_W-1:0] bus_nibble;
      logic [TICKS_W-1:0]  hold_ticks;
      logic                last_phase;
   } rsp_type;

   typedef enum logic [1:0] {
      SEL_KEEP,
      SEL_CMD,
      SEL_DATA
   } sel_src_type;

   typedef enum logic [1:0] {
      NIB_KEEP,
      NIB_HIGH,
      NIB_LOW
   } nib_src_type;

   // One control word of the microprogram
   typedef struct packed {
      logic [STEP_W-1:0] next_step;
      logic              last;
      logic              enable;
      sel_src_type       sel_src;
      nib_src_type       nib_src;
      logic              use_wrap;
      logic              use_settle;
      logic              count_col;
   } ucode_type;

   // Sequencer to datapath control
   typedef struct packed {
      logic      fire;
      ucode_type word;
   } seq_ctrl_type;

   // Entry points of the microprogram
   localparam logic [STEP_W-1:0] STEP_CMD    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_SETTLE = 4'd5;
   localparam logic [STEP_W-1:0] STEP_WRAP   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DATA   = 4'd11;

   function automatic ucode_type mk_word(
      input logic [STEP_W-1:0] next_step,
      input logic              last,
      input logic              enable,
      input sel_src_type       sel_src,
      input nib_src_type       nib_src,
      input logic              use_wrap,
      input logic              use_settle,
      input logic              count_col
   );
      ucode_type w;
      w.next_step  = next_step;
      w.last       = last;
      w.enable     = enable;
      w.sel_src    = sel_src;
      w.nib_src    = nib_src;
      w.use_wrap   = use_wrap;
      w.use_settle = use_settle;
      w.count_col  = count_col;
      return w;
   endfunction

   // Microprogram: command, settle, wrap command, data character
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         // command byte: enable low with old pins, then two nibbles
         4'd0:  w = mk_word(4'd1,  1'b0, 1'b0, SEL_KEEP, NIB_KEEP, 1'b0, 1'b0, 1'b0);
         4'd1:  w = mk_word(4'd2,  1'b0, 1'b1, SEL_CMD,  NIB_HIGH, 1'b0, 1'b0, 1'b0);
         4'd2:  w = mk_word(4'd3,  1'b0, 1'b0, SEL_CMD,  NIB_HIGH, 1'b0, 1'b0, 1'b0);
         4'd3:  w = mk_word(4'd4,  1'b0, 1'b1, SEL_CMD,  NIB_LOW,  1'b0, 1'b0, 1'b0);
         4'd4:  w = mk_word(4'd0,  1'b1, 1'b0, SEL_CMD,  NIB_LOW,  1'b0, 1'b0, 1'b0);
         // settle before the first character of a string
         4'd5:  w = mk_word(STEP_DATA, 1'b0, 1'b0, SEL_KEEP, NIB_KEEP, 1'b0, 1'b1, 1'b0);
         // wrap command ahead of a character
         4'd6:  w = mk_word(4'd7,  1'b0, 1'b0, SEL_KEEP, NIB_KEEP, 1'b1, 1'b0, 1'b0);
         4'd7:  w = mk_word(4'd8,  1'b0, 1'b1, SEL_CMD,  NIB_HIGH, 1'b1, 1'b0, 1'b0);
         4'd8:  w = mk_word(4'd9,  1'b0, 1'b0, SEL_CMD,  NIB_HIGH, 1'b1, 1'b0, 1'b0);
         4'd9:  w = mk_word(4'd10, 1'b0, 1'b1, SEL_CMD,  NIB_LOW,  1'b1, 1'b0, 1'b0);
         4'd10: w = mk_word(STEP_DATA, 1'b0, 1'b0, SEL_CMD, NIB_LOW, 1'b1, 1'b0, 1'b0);
         // data character with select high
         4'd11: w = mk_word(4'd12, 1'b0, 1'b1, SEL_DATA, NIB_HIGH, 1'b0, 1'b0, 1'b0);
         4'd12: w = mk_word(4'd13, 1'b0, 1'b0, SEL_DATA, NIB_HIGH, 1'b0, 1'b0, 1'b0);
         4'd13: w = mk_word(4'd14, 1'b0, 1'b1, SEL_DATA, NIB_LOW,  1'b0, 1'b0, 1'b0);
         4'd14: w = mk_word(4'd0,  1'b1, 1'b0, SEL_DATA, NIB_LOW,  1'b0, 1'b0, 1'b1);
         default: w = mk_word(4'd0, 1'b1, 1'b0, SEL_KEEP, NIB_KEEP, 1'b0, 1'b0, 1'b0);
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/char_lcd_nibble_writer.sv =====
// Character LCD writer for a 4-bit bus.
// Request channel (req_valid, req_stall, req_data): one beat is one command
// byte or one data character. Each byte becomes a run of pin-state beats on
// the response channel (rsp_valid, rsp_stall, rsp_data): select, enable,
// nibble and the number of timer ticks to hold that state. The final beat of
// a byte carries last_phase.
// A command gives 5 beats; a character gives 4, plus 1 settle beat when it
// opens a string, plus 5 wrap-command beats when the column reaches the line
// length (at most 9). One beat leaves per cycle from a microprogram step
// counter while the response side does not stall; the step and busy registers
// load when the request is taken, and each beat is then registered in the
// response register. The next request is taken in the cycle after the last step.
// req_stall stays high while a byte is in progress. A stall on the response
// side freezes the sequencer and holds the pending beat.
// Reset (synchronous) returns the registers to their defaults, clears the pin
// state and column count and empties the response register.
// The csr port writes wait_ticks, settle_ticks, line_length and wrap_command
// by index; write only while idle.
module char_lcd_nibble_writer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  lcdnw_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output lcdnw_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [lcdnw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lcdnw_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import lcdnw_pkg::*;

   logic [TICKS_W-1:0]  wait_ticks_ff;
   logic [TICKS_W-1:0]  settle_ticks_ff;
   logic [COLUMN_W-1:0] line_length_ff;
   logic [BYTE_W-1:0]   wrap_command_ff;
   logic                load;
   logic                wrap_hit;
   logic                advance;
   seq_ctrl_type        ctrl;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ticks_ff   <= WAIT_TICKS_RST;
         settle_ticks_ff <= SETTLE_TICKS_RST;
         line_length_ff  <= LINE_LENGTH_RST;
         wrap_command_ff <= WRAP_COMMAND_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WAIT_TICKS:   wait_ticks_ff   <= csr_wr_data[TICKS_W-1:0];
            CSR_SETTLE_TICKS: settle_ticks_ff <= csr_wr_data[TICKS_W-1:0];
            CSR_LINE_LENGTH:  line_length_ff  <= csr_wr_data[COLUMN_W-1:0];
            CSR_WRAP_COMMAND: wrap_command_ff <= csr_wr_data[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   lcdnw_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .wrap_hit  (wrap_hit),
      .advance   (advance),
      .req_stall (req_stall),
      .load      (load),
      .ctrl      (ctrl)
   );

   lcdnw_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .req_data     (req_data),
      .ctrl         (ctrl),
      .wait_ticks   (wait_ticks_ff),
      .settle_ticks (settle_ticks_ff),
      .line_length  (line_length_ff),
      .wrap_command (wrap_command_ff),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .wrap_hit     (wrap_hit),
      .advance      (advance)
   );

endmodule

// ===== hw/rtl/lcdnw_sequencer.sv =====
module lcdnw_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  lcdnw_pkg::req_type    req_data,
   input  logic                  wrap_hit,
   input  logic                  advance,
   output logic                  req_stall,
   output logic                  load,
   output lcdnw_pkg::seq_ctrl_type ctrl
);
   import lcdnw_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] entry;
   ucode_type         word;
   logic              fire;

   assign req_stall = busy_ff;
   assign load      = req_valid && !busy_ff;
   assign word      = ucode_rom(step_ff);
   assign fire      = busy_ff && advance;

   assign ctrl.fire = fire;
   assign ctrl.word = word;

   // Dispatch: pick the entry point of the microprogram
   always_comb begin
      if (req_data.operation == OP_COMMAND) begin
         entry = STEP_CMD;
      end else if (req_data.first_of_string) begin
         entry = STEP_SETTLE;
      end else if (wrap_hit) begin
         entry = STEP_WRAP;
      end else begin
         entry = STEP_DATA;
      end
   end

   // Advance the step counter, drop busy after the last step
   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      if (load) begin
         step_in = entry;
         busy_in = 1'b1;
      end else if (fire) begin
         step_in = word.next_step;
         busy_in = !word.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_CMD;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== hw/rtl/lcdnw_datapath.sv =====
module lcdnw_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  lcdnw_pkg::req_type                  req_data,
   input  lcdnw_pkg::seq_ctrl_type             ctrl,
   input  logic [lcdnw_pkg::TICKS_W-1:0]       wait_ticks,
   input  logic [lcdnw_pkg::TICKS_W-1:0]       settle_ticks,
   input  logic [lcdnw_pkg::COLUMN_W-1:0]      line_length,
   input  logic [lcdnw_pkg::BYTE_W-1:0]        wrap_command,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output lcdnw_pkg::rsp_type                  rsp_data,
   output logic                                wrap_hit,
   output logic                                advance
);
   import lcdnw_pkg::*;

   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                sel_ff, sel_in;
   logic [NIBBLE_W-1:0] nib_ff, nib_in;
   logic [COLUMN_W-1:0] col_ff, col_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [BYTE_W-1:0]   src_byte;
   logic [TICKS_W-1:0]  hold_raw;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign wrap_hit  = (line_length != '0) && (col_ff == line_length);

   // Select byte and hold time for this step
   assign src_byte = ctrl.word.use_wrap ? wrap_command : byte_ff;
   assign hold_raw = ctrl.word.use_settle ? settle_ticks : wait_ticks;

   // Pin state of the current step
   always_comb begin
      case (ctrl.word.sel_src)
         SEL_CMD:  sel_in = 1'b0;
         SEL_DATA: sel_in = 1'b1;
         default:  sel_in = sel_ff;
      endcase
      case (ctrl.word.nib_src)
         NIB_HIGH: nib_in = src_byte[BYTE_W-1 -: NIBBLE_W];
         NIB_LOW:  nib_in = src_byte[NIBBLE_W-1:0];
         default:  nib_in = nib_ff;
      endcase
   end

   // Output beat register and column count
   always_comb begin
      byte_in      = byte_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         byte_in = req_data.byte_value;
         if (req_data.operation == OP_DATA && req_data.first_of_string) begin
            col_in = '0;
         end
      end
      if (ctrl.fire) begin
         rsp_valid_in        = 1'b1;
         rsp_in.select_level = sel_in;
         rsp_in.enable_level = ctrl.word.enable;
         rsp_in.bus_nibble   = nib_in;
         rsp_in.hold_ticks   = (hold_raw == '0) ? TICKS_W'(1) : hold_raw;
         rsp_in.last_phase   = ctrl.word.last;
         if (ctrl.word.count_col && col_ff != COLUMN_MAX) begin
            col_in = col_ff + COLUMN_W'(1);
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         sel_ff       <= 1'b0;
         nib_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.fire) begin
            sel_ff <= sel_in;
            nib_ff <= nib_in;
         end
      end
   end

endmodule

// ===== hw/rtl/lcdnw_checker.sv =====
module lcdnw_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  lcdnw_pkg::rsp_type    rsp_data
);
   import lcdnw_pkg::*;

   // A stalled beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // Every beat holds its pins for at least one tick
   a_hold_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.hold_ticks != '0)
      else $error("response beat with zero hold time");

   // A taken request keeps the channel closed for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a byte is in progress");

   // A byte always ends with enable low
   a_last_enable_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_phase |-> !rsp_data.enable_level)
      else $error("final beat of a byte has enable high");

endmodule

bind char_lcd_nibble_writer lcdnw_checker u_lcdnw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_top.sv =====
module tb_top;
   import lcdnw_pkg::*;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned RANDOM_PHASES = 6;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   char_lcd_nibble_writer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Bytes waiting to be offered, and pin states the LCD should see next
   req_type byte_backlog[$];
   rsp_type expected_pins[$];

   // Shadow of the register file
   logic [TICKS_W-1:0]  cfg_wait   = WAIT_TICKS_RST;
   logic [TICKS_W-1:0]  cfg_settle = SETTLE_TICKS_RST;
   logic [COLUMN_W-1:0] cfg_line   = LINE_LENGTH_RST;
   logic [BYTE_W-1:0]   cfg_wrap   = WRAP_COMMAND_RST;

   // Shadow of the pins and the cursor column
   logic                pin_sel = 1'b0;
   logic                pin_en  = 1'b0;
   logic [NIBBLE_W-1:0] pin_nib = '0;
   logic [COLUMN_W-1:0] cursor_col = '0;

   int unsigned errors = 0;
   int unsigned bytes_sent = 0;
   int unsigned beats_checked = 0;
   int unsigned wraps_seen = 0;
   int unsigned settings_used = 0;
   bit          calm = 1'b0;
   int          req_gap = 0;
   int          stall_left = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // Drive the pins to a new state and queue it as the next expected beat
   function automatic void emit_pins(logic sel, logic en, logic [NIBBLE_W-1:0] nib,
                                     logic [TICKS_W-1:0] hold);
      rsp_type beat;
      pin_sel = sel;
      pin_en  = en;
      pin_nib = nib;
      beat.select_level = sel;
      beat.enable_level = en;
      beat.bus_nibble   = nib;
      beat.hold_ticks   = (hold == '0) ? TICKS_W'(1) : hold;
      beat.last_phase   = 1'b0;
      expected_pins.push_back(beat);
   endfunction

   // Strobe a byte out as high nibble then low nibble
   function automatic void emit_nibbles(logic sel, logic [BYTE_W-1:0] value);
      emit_pins(sel, 1'b1, value[7:4], cfg_wait);
      emit_pins(sel, 1'b0, value[7:4], cfg_wait);
      emit_pins(sel, 1'b1, value[3:0], cfg_wait);
      emit_pins(sel, 1'b0, value[3:0], cfg_wait);
   endfunction

   function automatic void emit_command(logic [BYTE_W-1:0] value);
      emit_pins(pin_sel, 1'b0, pin_nib, cfg_wait);
      emit_nibbles(1'b0, value);
   endfunction

   // Work out every pin state one request byte produces
   function automatic void expand_byte(req_type item);
      rsp_type tail;
      if (item.operation == OP_COMMAND) begin
         emit_command(item.byte_value);
      end else begin
         if (item.first_of_string) begin
            cursor_col = '0;
            emit_pins(pin_sel, 1'b0, pin_nib, cfg_settle);
         end
         if (cfg_line != '0 && cursor_col == cfg_line) begin
            emit_command(cfg_wrap);
            wraps_seen++;
         end
         emit_nibbles(1'b1, item.byte_value);
         if (cursor_col < COLUMN_MAX) cursor_col = cursor_col + 1'b1;
      end
      tail = expected_pins.pop_back();
      tail.last_phase = 1'b1;
      expected_pins.push_back(tail);
   endfunction

   // Request side: present backlog bytes, predict on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expand_byte(req_data);
            bytes_sent++;
            if (!calm && $urandom_range(0, 3) == 0) req_gap = $urandom_range(1, 18);
         end else if (!req_valid && !calm && req_gap == 0 && $urandom_range(0, 15) == 0) begin
            req_gap = $urandom_range(1, 18);
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (byte_backlog.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= byte_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response side: check each pin beat, stall in bursts
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pins.size() == 0) begin
               errors++;
               $display("%0t: unexpected pin beat sel=%0b en=%0b nib=%h hold=%0d last=%0b",
                        $time, rsp_data.select_level, rsp_data.enable_level,
                        rsp_data.bus_nibble, rsp_data.hold_ticks, rsp_data.last_phase);
            end else begin
               want = expected_pins.pop_front();
               beats_checked++;
               if (rsp_data.select_level !== want.select_level ||
                   rsp_data.enable_level !== want.enable_level ||
                   rsp_data.bus_nibble   !== want.bus_nibble   ||
                   rsp_data.hold_ticks   !== want.hold_ticks   ||
                   rsp_data.last_phase   !== want.last_phase) begin
                  errors++;
                  $display("%0t: pin mismatch expected sel=%0b en=%0b nib=%h hold=%0d last=%0b",
                           $time, want.select_level, want.enable_level, want.bus_nibble,
                           want.hold_ticks, want.last_phase);
                  $display("%0t:              actual   sel=%0b en=%0b nib=%h hold=%0d last=%0b",
                           $time, rsp_data.select_level, rsp_data.enable_level,
                           rsp_data.bus_nibble, rsp_data.hold_ticks, rsp_data.last_phase);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: end the run if no beat moves for too long
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("char_lcd_nibble_writer verification failed");
      $finish;
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      case (idx)
         CSR_WAIT_TICKS:   cfg_wait   = value;
         CSR_SETTLE_TICKS: cfg_settle = value;
         CSR_LINE_LENGTH:  cfg_line   = value[COLUMN_W-1:0];
         CSR_WRAP_COMMAND: cfg_wrap   = value[BYTE_W-1:0];
         default: ;
      endcase
   endtask

   // Load all four registers; junk upper bits where asked
   task automatic load_settings(logic [15:0] wait_v, logic [15:0] settle_v,
                                logic [5:0] line_v, logic [7:0] wrap_v, bit junk);
      logic [15:0] upper;
      upper = junk ? 16'($urandom) : 16'h0;
      csr_write(CSR_WAIT_TICKS, wait_v);
      csr_write(CSR_SETTLE_TICKS, settle_v);
      csr_write(CSR_LINE_LENGTH, {upper[15:6], line_v});
      csr_write(CSR_WRAP_COMMAND, {upper[15:8], wrap_v});
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Hold until every byte has gone and every pin beat has come back
   task automatic drain();
      @(negedge clock);
      while (byte_backlog.size() != 0 || req_valid || expected_pins.size() != 0)
         @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic void queue_byte(logic op, logic [7:0] value, logic first);
      req_type item;
      item.operation       = op;
      item.byte_value      = value;
      item.first_of_string = first;
      byte_backlog.push_back(item);
   endfunction

   // A string of characters with the odd command and stray string start
   function automatic int queue_string(int len);
      int n;
      n = 0;
      for (int i = 0; i < len; i++) begin
         queue_byte(OP_DATA, 8'($urandom), (i == 0) ? 1'b1 : ($urandom_range(0, 19) == 0));
         n++;
         if ($urandom_range(0, 6) == 0) begin
            queue_byte(OP_COMMAND, 8'($urandom), 1'($urandom));
            n++;
         end
      end
      return n;
   endfunction

   initial begin
      int          queued;
      int          target;
      logic [15:0] wait_v;
      logic [15:0] settle_v;
      logic [5:0]  line_v;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, commands, first character, byte extremes
      queue_byte(OP_COMMAND, 8'h28, 1'b0);
      queue_byte(OP_COMMAND, 8'hFF, 1'b1);
      queue_byte(OP_DATA, 8'hA5, 1'b1);
      queue_byte(OP_DATA, 8'h00, 1'b0);
      queue_byte(OP_DATA, 8'hFF, 1'b0);
      drain();

      // Directed: zero hold times, short line so the wrap fires
      load_settings(16'h0000, 16'h0000, 6'd2, 8'h80, 1'b0);
      queue_byte(OP_DATA, 8'h41, 1'b1);
      queue_byte(OP_DATA, 8'h42, 1'b0);
      queue_byte(OP_DATA, 8'h43, 1'b0);
      queue_byte(OP_DATA, 8'h44, 1'b0);
      queue_byte(OP_DATA, 8'h45, 1'b1);
      queue_byte(OP_COMMAND, 8'h01, 1'b0);
      queue_byte(OP_DATA, 8'h46, 1'b0);
      queue_byte(OP_DATA, 8'h47, 1'b0);
      drain();

      // Directed: line length zero never wraps, widest hold times
      load_settings(16'hFFFF, 16'hFFFF, 6'd0, 8'hFF, 1'b0);
      queue_byte(OP_DATA, 8'h5A, 1'b1);
      queue_byte(OP_DATA, 8'hC3, 1'b0);
      queue_byte(OP_DATA, 8'h3C, 1'b0);
      queue_byte(OP_COMMAND, 8'h00, 1'b1);
      queue_byte(OP_DATA, 8'h99, 1'b0);
      drain();

      // Random phases, each under its own settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 4))
            0: wait_v = 16'h0000;
            1: wait_v = 16'h0001;
            2: wait_v = 16'hFFFF;
            default: wait_v = 16'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0: settle_v = 16'h0000;
            1: settle_v = 16'h0001;
            2: settle_v = 16'hFFFF;
            default: settle_v = 16'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0: line_v = 6'd0;
            1: line_v = 6'd1;
            2: line_v = 6'd40;
            3: line_v = 6'd63;
            default: line_v = 6'($urandom_range(2, 39));
         endcase
         if (p == 2) line_v = 6'd63;
         load_settings(wait_v, settle_v, line_v, 8'($urandom), $urandom_range(0, 2) == 0);
         calm = (p == RANDOM_PHASES - 1) || ($urandom_range(0, 3) == 0);

         queued = 0;
         target = 50 + $urandom_range(0, 10);
         // Saturate the column with one string longer than the widest line
         if (p == 2) queued += queue_string(70);
         while (queued < target) begin
            if ($urandom_range(0, 5) == 0) begin
               queue_byte(OP_COMMAND, 8'($urandom), 1'($urandom));
               queued++;
            end else if ($urandom_range(0, 4) == 0) begin
               queued += queue_string($urandom_range(13, 45));
            end else begin
               queued += queue_string($urandom_range(1, 12));
            end
         end
         drain();
      end

      if (expected_pins.size() != 0) begin
         errors++;
         $display("%0t: %0d pin beats never arrived", $time, expected_pins.size());
      end
      $display("Ran %0d bytes through %0d register settings; %0d pin beats checked, %0d wraps.",
               bytes_sent, settings_used, beats_checked, wraps_seen);
      if (errors == 0) begin
         $display("char_lcd_nibble_writer verification clean");
      end else begin
         $display("char_lcd_nibble_writer verification failed");
      end
      $finish;
   end

endmodule
